// ===== rtl/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the timestamp priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int STAMP_W         = 16;
    localparam int PID_W           = 4;
    localparam int ENTRY_W         = STAMP_W + PID_W;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [PID_W-1:0]   pid_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INSERT,
        ST_POP_RD,
        ST_POP_LD,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/tpq_ram.sv =====
// ----------------------------------------------------------------------------
// tpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int WIDTH = tpq_pkg::ENTRY_W,
    parameter int DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/timestamp_priority_queue_core.sv =====
// Sequencing: a pop fetches a new head from the RAM when entries remain; a push
//   into an empty or full queue goes straight to the result, otherwise it scans
//   from the tail, moving each larger entry back one slot (at most QUEUE_DEPTH-1
//   of them), and writes the item at the head slot when it becomes the new head.
// Flow: one item at a time; the insert scan through the entry RAM reads and
//   compares one entry at a time.
// Reset: asynchronous, clears the fill count, the base pointer and the sequencer; RAM not cleared.
// ----------------------------------------------------------------------------
// timestamp_priority_queue_core
// Priority queue of (stamp, process id) pairs kept sorted in a circular RAM.
// ----------------------------------------------------------------------------
module timestamp_priority_queue_core #(
    parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [tpq_pkg::STAMP_W-1:0] stamp,
    input  logic [tpq_pkg::PID_W-1:0]   process_id,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tpq_pkg::PID_W-1:0]   popped_id,
    output logic [tpq_pkg::PID_W-1:0]   head_id,
    output logic                        is_empty,
    output logic                        overflow
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    tpq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    tpq_pkg::entry_t item_reg, item_next;
    tpq_pkg::pid_t   head_pid_reg, head_pid_next;
    tpq_pkg::pid_t   popped_reg, popped_next;
    logic            ovf_reg, ovf_next;

    logic            accept;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    tpq_pkg::entry_t wdata, rdata;
    tpq_pkg::entry_t in_item;

    logic [AW:0]     sum_idx, sum_idx1, sum_base1;
    logic [AW-1:0]   addr_idx, addr_idx1, base_inc;

    assign accept  = in_valid && (state_reg == tpq_pkg::ST_IDLE);
    assign in_item = {stamp, process_id};

    // Circular addressing: base plus offset, folded back below the depth.
    always_comb
    begin
        sum_idx   = {1'b0, base_reg} + {1'b0, idx_reg};
        sum_idx1  = sum_idx + (AW+1)'(1);
        sum_base1 = {1'b0, base_reg} + (AW+1)'(1);
        addr_idx  = (sum_idx   >= DEPTH_A) ? AW'(sum_idx   - DEPTH_A) : sum_idx[AW-1:0];
        addr_idx1 = (sum_idx1  >= DEPTH_A) ? AW'(sum_idx1  - DEPTH_A) : sum_idx1[AW-1:0];
        base_inc  = (sum_base1 >= DEPTH_A) ? AW'(sum_base1 - DEPTH_A) : sum_base1[AW-1:0];
    end

    tpq_ram #(
        .WIDTH(tpq_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == tpq_pkg::OP_PUSH)
                    begin
                        if (count_reg == DEPTH_C || count_reg == '0)
                            state_next = tpq_pkg::ST_DONE;
                        else
                            state_next = tpq_pkg::ST_SCAN_RD;
                    end
                    else
                    begin
                        if (count_reg > CW'(1))
                            state_next = tpq_pkg::ST_POP_RD;
                        else
                            state_next = tpq_pkg::ST_DONE;
                    end
                end
            end
            tpq_pkg::ST_SCAN_RD:  state_next = tpq_pkg::ST_SCAN_CMP;
            tpq_pkg::ST_SCAN_CMP:
            begin
                if (rdata > item_reg)
                    state_next = (idx_reg == '0) ? tpq_pkg::ST_INSERT : tpq_pkg::ST_SCAN_RD;
                else
                    state_next = tpq_pkg::ST_DONE;
            end
            tpq_pkg::ST_INSERT:   state_next = tpq_pkg::ST_DONE;
            tpq_pkg::ST_POP_RD:   state_next = tpq_pkg::ST_POP_LD;
            tpq_pkg::ST_POP_LD:   state_next = tpq_pkg::ST_DONE;
            tpq_pkg::ST_DONE:
            begin
                if (!out_stall)
                    state_next = tpq_pkg::ST_IDLE;
            end
            default:              state_next = tpq_pkg::ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        base_next     = base_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        item_next     = item_reg;
        head_pid_next = head_pid_reg;
        popped_next   = popped_reg;
        ovf_next      = ovf_reg;
        we            = 1'b0;
        waddr         = addr_idx1;
        wdata         = item_reg;
        raddr         = addr_idx;
        unique case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    ovf_next    = 1'b0;
                    item_next   = in_item;
                    idx_next    = AW'(count_reg - CW'(1));
                    if (operation == tpq_pkg::OP_PUSH)
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            ovf_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            // empty queue: item becomes the head directly
                            we            = 1'b1;
                            waddr         = base_reg;
                            wdata         = in_item;
                            head_pid_next = process_id;
                            count_next    = CW'(1);
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        popped_next = head_pid_reg;
                        base_next   = base_inc;
                        count_next  = count_reg - CW'(1);
                    end
                end
            end
            tpq_pkg::ST_SCAN_CMP:
            begin
                we = 1'b1;
                if (rdata > item_reg)
                begin
                    // move the larger entry back one slot; scan on, or insert at the head after slot 0
                    wdata = rdata;
                    if (idx_reg != '0)
                        idx_next = idx_reg - AW'(1);
                end
                else
                begin
                    wdata      = item_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            tpq_pkg::ST_INSERT:
            begin
                we            = 1'b1;
                waddr         = base_reg;
                wdata         = item_reg;
                head_pid_next = item_reg[tpq_pkg::PID_W-1:0];
                count_next    = count_reg + CW'(1);
            end
            tpq_pkg::ST_POP_RD:
            begin
                raddr = base_reg;
            end
            tpq_pkg::ST_POP_LD:
            begin
                head_pid_next = rdata[tpq_pkg::PID_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpq_pkg::ST_IDLE;
            base_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        item_reg     <= item_next;
        head_pid_reg <= head_pid_next;
        popped_reg   <= popped_next;
        ovf_reg      <= ovf_next;
    end

    assign in_stall  = (state_reg != tpq_pkg::ST_IDLE);
    assign out_valid = (state_reg == tpq_pkg::ST_DONE);
    assign popped_id = popped_reg;
    assign is_empty  = (count_reg == '0);
    assign head_id   = is_empty ? '0 : head_pid_reg;
    assign overflow  = ovf_reg;

endmodule

// ===== rtl/tpq_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_checker
// Port-level checks on the timestamp priority queue core.
// ----------------------------------------------------------------------------
module tpq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tpq_pkg::PID_W-1:0]   popped_id,
    input logic [tpq_pkg::PID_W-1:0]   head_id,
    input logic                        is_empty,
    input logic                        overflow
);

    // An empty queue reports no head.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> head_id == '0)
        else $error("head_id nonzero on empty queue");

    // A dropped push leaves a full, non-empty queue and pops nothing.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> !is_empty && popped_id == '0)
        else $error("overflow reported with empty queue or popped id");

    // One item in flight: no transfer is taken while a result waits.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(popped_id) && $stable(head_id)
            && $stable(is_empty) && $stable(overflow))
        else $error("stalled result changed");

endmodule

bind timestamp_priority_queue_core tpq_checker u_tpq_checker (.*);
